FILE: hw/rtl/apd_pkg.sv
package apd_pkg;

	localparam int AVG_WINDOW    = 30;
	localparam int BLOCK_SAMPLES = 700;

	localparam int SAMPLE_W = 16;
	localparam int TIME_W   = 32;
	localparam int COEF_W   = 12;
	localparam int MAXLEN_W = 16;
	localparam int FRAC_W   = 8;

	localparam int SLOT_W  = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
	localparam int FILL_W  = $clog2(AVG_WINDOW + 1);
	localparam int SUM_W   = SAMPLE_W + SLOT_W;
	localparam int DCNT_W  = $clog2(SUM_W + 1);
	localparam int BLK_W   = $clog2(BLOCK_SAMPLES + 1);
	localparam int SCALE_W = SAMPLE_W + FRAC_W;
	localparam int PROD_W  = COEF_W + SAMPLE_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_COEF = 2'd0,
		CFG_END_COEF   = 2'd1,
		CFG_MAX_LEN    = 2'd2,
		CFG_UNUSED     = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE,
		ST_COMPARE,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic [COEF_W-1:0]   start_coef;
		logic [COEF_W-1:0]   end_coef;
		logic [MAXLEN_W-1:0] max_len_ms;
	} det_cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [FILL_W-1:0] fill;
	} win_t;

	typedef struct packed {
		logic found;
		logic done;
	} det_res_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic div_start;
		logic mul_en;
		logic dec_fire;
	} seq_ctl_t;

endpackage

FILE: hw/rtl/adaptive_pulse_detector_unit.sv
// Adaptive pulse detector: running-average light threshold detector.
//
// Input channel: in_valid / in_stall carry one item (sample, now_ms). The
// unit stalls the input while an item is in work, so items go one at a time.
// Output channel: out_valid / out_stall carry one result per item (average,
// pulse_found, block_done) from an output register.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// start_coef, 1 end_coef, 2 max_len_ms, index 3 is ignored. Always ready;
// write only while the unit is idle.
//
// Run: after the item is accepted it passes a ring read-modify-write,
// the bit-serial sum/count divider, a multiply step and a decision step.
// The input is free again in the same cycle the result reaches the output
// register, so the unit takes no new item before the last one is done.
// If the receiver stalls, the finished result holds in the output register;
// the next item still runs and waits in its decision step until the
// register frees up.
// Reset clears ring bookkeeping, pulse state, block count and restores the
// register defaults; ring contents are masked by the fill count, no sweep.
module adaptive_pulse_detector_unit (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [apd_pkg::SAMPLE_W-1:0]    sample,
	input  logic [apd_pkg::TIME_W-1:0]      now_ms,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [apd_pkg::SAMPLE_W-1:0]    average,
	output logic                            pulse_found,
	output logic                            block_done,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [apd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [apd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	apd_pkg::state_t   state_q, state_nxt;
	apd_pkg::seq_ctl_t ctl;
	apd_pkg::det_cfg_t cfg_q;
	apd_pkg::win_t     win_nxt;
	apd_pkg::det_res_t det_res;

	logic [apd_pkg::SAMPLE_W-1:0] sample_q;
	logic [apd_pkg::TIME_W-1:0]   now_q;
	logic [apd_pkg::SAMPLE_W-1:0] quotient;
	logic                         div_last;
	logic                         in_take;
	logic                         out_free;

	assign in_stall  = (state_q != apd_pkg::ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign cfg_ready = 1'b1;

	// Configuration registers; unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_coef <= apd_pkg::COEF_W'(384);
			cfg_q.end_coef   <= apd_pkg::COEF_W'(282);
			cfg_q.max_len_ms <= apd_pkg::MAXLEN_W'(1000);
		end else if (cfg_valid && cfg_ready) begin
			unique case (apd_pkg::cfg_idx_t'(cfg_index))
				apd_pkg::CFG_START_COEF: cfg_q.start_coef <= cfg_data[apd_pkg::COEF_W-1:0];
				apd_pkg::CFG_END_COEF:   cfg_q.end_coef   <= cfg_data[apd_pkg::COEF_W-1:0];
				apd_pkg::CFG_MAX_LEN:    cfg_q.max_len_ms <= cfg_data[apd_pkg::MAXLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold the accepted item for the whole run.
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= sample;
			now_q    <= now_ms;
		end
	end

	// Sequencer: next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			apd_pkg::ST_IDLE:    if (in_take) state_nxt = apd_pkg::ST_UPDATE;
			apd_pkg::ST_UPDATE:  state_nxt = apd_pkg::ST_DIVIDE;
			apd_pkg::ST_DIVIDE:  if (div_last) state_nxt = apd_pkg::ST_COMPARE;
			apd_pkg::ST_COMPARE: state_nxt = apd_pkg::ST_DECIDE;
			apd_pkg::ST_DECIDE:  if (out_free) state_nxt = apd_pkg::ST_IDLE;
			default:             state_nxt = apd_pkg::ST_IDLE;
		endcase
	end

	// Sequencer: strobes to the datapath.
	always_comb begin
		ctl = '0;
		unique case (state_q)
			apd_pkg::ST_IDLE: begin
				ctl.rd_en = in_take;
			end
			apd_pkg::ST_UPDATE: begin
				ctl.wr_en     = 1'b1;
				ctl.div_start = 1'b1;
			end
			apd_pkg::ST_COMPARE: begin
				ctl.mul_en = 1'b1;
			end
			apd_pkg::ST_DECIDE: begin
				ctl.dec_fire = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Ring memory read-modify-write of the running sum.
	apd_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ctl.rd_en),
		.wr_en   (ctl.wr_en),
		.sample  (sample_q),
		.win_nxt (win_nxt)
	);

	// Average = sum / fill, started on the updated sum.
	apd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (win_nxt.sum),
		.divisor  (win_nxt.fill),
		.last     (div_last),
		.quotient (quotient)
	);

	apd_detect u_detect (
		.clk      (clk),
		.arst_n   (arst_n),
		.mul_en   (ctl.mul_en),
		.dec_fire (ctl.dec_fire),
		.cfg      (cfg_q),
		.sample   (sample_q),
		.now_ms   (now_q),
		.average  (quotient),
		.res      (det_res)
	);

	// Output register: load on decision, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.dec_fire) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.dec_fire) begin
			average     <= quotient;
			pulse_found <= det_res.found;
			block_done  <= det_res.done;
		end
	end

endmodule

FILE: hw/rtl/apd_window.sv
module apd_window (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic                           wr_en,
	input  logic [apd_pkg::SAMPLE_W-1:0]   sample,
	output apd_pkg::win_t                  win_nxt
);

	logic [apd_pkg::SAMPLE_W-1:0] ring_mem [apd_pkg::AVG_WINDOW];
	logic [apd_pkg::SAMPLE_W-1:0] rd_data_q;
	logic [apd_pkg::SLOT_W-1:0]   slot_q;
	logic [apd_pkg::FILL_W-1:0]   fill_q;
	logic [apd_pkg::SUM_W-1:0]    sum_q;
	logic [apd_pkg::SAMPLE_W-1:0] old_sample;
	logic                         full;

	// Slot being overwritten was written before only once the window is full.
	assign full       = (fill_q == apd_pkg::FILL_W'(apd_pkg::AVG_WINDOW));
	assign old_sample = full ? rd_data_q : '0;

	always_comb begin
		win_nxt.sum  = sum_q - apd_pkg::SUM_W'(old_sample) + apd_pkg::SUM_W'(sample);
		win_nxt.fill = full ? fill_q : fill_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[slot_q] <= sample;
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (wr_en) begin
			sum_q  <= win_nxt.sum;
			fill_q <= win_nxt.fill;
			if (slot_q == apd_pkg::SLOT_W'(apd_pkg::AVG_WINDOW - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/apd_div.sv
module apd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [apd_pkg::SUM_W-1:0]     dividend,
	input  logic [apd_pkg::FILL_W-1:0]    divisor,
	output logic                          last,
	output logic [apd_pkg::SAMPLE_W-1:0]  quotient
);

	logic                        busy_q;
	logic [apd_pkg::DCNT_W-1:0]  cnt_q;
	logic [apd_pkg::SUM_W-1:0]   quo_q;
	logic [apd_pkg::FILL_W-1:0]  den_q;
	logic [apd_pkg::FILL_W-1:0]  rem_q;
	logic [apd_pkg::FILL_W:0]    trial;
	logic                        ge;
	logic [apd_pkg::FILL_W:0]    diff;

	// Restoring division, one quotient bit per cycle.
	assign trial    = {rem_q, quo_q[apd_pkg::SUM_W-1]};
	assign ge       = (trial >= {1'b0, den_q});
	assign diff     = trial - {1'b0, den_q};
	assign last     = busy_q && (cnt_q == apd_pkg::DCNT_W'(apd_pkg::SUM_W - 1));
	assign quotient = quo_q[apd_pkg::SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[apd_pkg::SUM_W-2:0], ge};
			rem_q <= ge ? diff[apd_pkg::FILL_W-1:0] : trial[apd_pkg::FILL_W-1:0];
		end
	end

endmodule

FILE: hw/rtl/apd_detect.sv
module apd_detect (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mul_en,
	input  logic                          dec_fire,
	input  apd_pkg::det_cfg_t             cfg,
	input  logic [apd_pkg::SAMPLE_W-1:0]  sample,
	input  logic [apd_pkg::TIME_W-1:0]    now_ms,
	input  logic [apd_pkg::SAMPLE_W-1:0]  average,
	output apd_pkg::det_res_t             res
);

	logic                         in_pulse_q;
	logic [apd_pkg::TIME_W-1:0]   start_ms_q;
	logic [apd_pkg::BLK_W-1:0]    blk_q;
	logic [apd_pkg::BLK_W-1:0]    blk_inc;
	logic [apd_pkg::SCALE_W-1:0]  scaled_q;
	logic [apd_pkg::PROD_W-1:0]   start_thr_q;
	logic [apd_pkg::PROD_W-1:0]   end_thr_q;
	logic                         timeout_q;
	logic [apd_pkg::TIME_W-1:0]   elapsed;
	logic                         start_hit;
	logic                         end_hit;

	assign elapsed = now_ms - start_ms_q;

	// Products and timeout flag, registered ahead of the decision.
	always_ff @(posedge clk) begin
		if (mul_en) begin
			scaled_q    <= {sample, {apd_pkg::FRAC_W{1'b0}}};
			start_thr_q <= apd_pkg::PROD_W'(cfg.start_coef) * apd_pkg::PROD_W'(average);
			end_thr_q   <= apd_pkg::PROD_W'(cfg.end_coef) * apd_pkg::PROD_W'(average);
			timeout_q   <= (elapsed > apd_pkg::TIME_W'(cfg.max_len_ms));
		end
	end

	assign start_hit = (apd_pkg::PROD_W'(scaled_q) > start_thr_q);
	assign end_hit   = (apd_pkg::PROD_W'(scaled_q) < end_thr_q);
	assign blk_inc   = blk_q + 1'b1;

	always_comb begin
		res.found = in_pulse_q && !timeout_q && end_hit;
		res.done  = (blk_inc == apd_pkg::BLK_W'(apd_pkg::BLOCK_SAMPLES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pulse_q <= 1'b0;
			start_ms_q <= '0;
			blk_q      <= '0;
		end else if (dec_fire) begin
			blk_q <= res.done ? '0 : blk_inc;
			if (!in_pulse_q) begin
				if (start_hit) begin
					in_pulse_q <= 1'b1;
					start_ms_q <= now_ms;
				end
			end else if (timeout_q || end_hit) begin
				in_pulse_q <= 1'b0;
			end
		end
	end

endmodule
